// File: sv/jste_pkg.sv
// ----------------------------------------------------------------------------
// jste_pkg
// Shared constants, field widths and types of the job shop tardiness
// evaluator.
// ----------------------------------------------------------------------------
package jste_pkg;

    localparam int MACHINES  = 16;
    localparam int JOBS      = 64;
    localparam int TIME_BITS = 24;

    localparam int MACH_BITS = 4;
    localparam int JOB_BITS  = 6;
    localparam int DUR_BITS  = 16;
    localparam int DUE_BITS  = 24;
    localparam int END_BITS  = 24;
    localparam int SUM_BITS  = 32;

    localparam int MACH_DEPTH = (MACHINES < (1 << MACH_BITS)) ? MACHINES : (1 << MACH_BITS);
    localparam int JOB_DEPTH  = (JOBS < (1 << JOB_BITS)) ? JOBS : (1 << JOB_BITS);
    localparam int MACH_AW    = (MACH_DEPTH > 1) ? $clog2(MACH_DEPTH) : 1;
    localparam int JOB_AW     = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

    localparam int EXT_BITS = ((TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS) + 1;
    localparam int CMP_BITS = (TIME_BITS > DUE_BITS) ? TIME_BITS : DUE_BITS;
    localparam int ACC_BITS = ((CMP_BITS > SUM_BITS) ? CMP_BITS : SUM_BITS) + 1;

    localparam logic FUNC_TASK = 1'b0;
    localparam logic FUNC_DUE  = 1'b1;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SUM_BITS-1:0]  sum_t;

    localparam time_t TIME_MAX = '1;
    localparam sum_t  SUM_MAX  = '1;

    typedef struct packed {
        logic                 func;
        logic [MACH_BITS-1:0] task_machine;
        logic [JOB_BITS-1:0]  task_job;
        logic [DUR_BITS-1:0]  duration;
        logic [DUE_BITS-1:0]  due_date;
        logic                 last_due;
    } item_t;

endpackage

// File: sv/jste_item_if.sv
// ----------------------------------------------------------------------------
// jste_item_if
// Input channel: one task or due-date transaction per valid/ready handshake.
// ----------------------------------------------------------------------------
interface jste_item_if;

    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [jste_pkg::MACH_BITS-1:0] task_machine;
    logic [jste_pkg::JOB_BITS-1:0]  task_job;
    logic [jste_pkg::DUR_BITS-1:0]  duration;
    logic [jste_pkg::DUE_BITS-1:0]  due_date;
    logic                           last_due;

    modport source (
        output valid,
        output func,
        output task_machine,
        output task_job,
        output duration,
        output due_date,
        output last_due,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  task_machine,
        input  task_job,
        input  duration,
        input  due_date,
        input  last_due,
        output ready
    );

endinterface

// File: sv/jste_result_if.sv
// ----------------------------------------------------------------------------
// jste_result_if
// Result channel: one end time / tardiness transaction per handshake.
// ----------------------------------------------------------------------------
interface jste_result_if;

    logic                          valid;
    logic                          ready;
    logic [jste_pkg::END_BITS-1:0] end_time;
    logic [jste_pkg::SUM_BITS-1:0] tardiness_total;
    logic                          total_done;

    modport source (
        output valid,
        output end_time,
        output tardiness_total,
        output total_done,
        input  ready
    );

    modport sink (
        input  valid,
        input  end_time,
        input  tardiness_total,
        input  total_done,
        output ready
    );

endinterface

// File: sv/job_shop_tardiness_evaluator_unit.sv
// ----------------------------------------------------------------------------
// job_shop_tardiness_evaluator_unit
// Pipeline: an accepted input transaction is registered into stage s1 while
// the job table RAM read is issued, then into the output register when s1 fires.
// Throughput: one transaction per cycle while result.ready is high; a
// write-to-read bypass covers the task that finishes in the accept cycle.
// Reset: tables read as zero at once (machine registers cleared, job table
// valid bits cleared); no clearing sweep, the last due item clears the same way.
// ----------------------------------------------------------------------------
module job_shop_tardiness_evaluator_unit (
    input  logic          clk,
    input  logic          rst_n,
    jste_item_if.sink     item,
    jste_result_if.source result
);

    jste_pkg::item_t in_item;
    logic            in_fire;
    logic            s1_fire;

    logic            s1_valid_reg;
    jste_pkg::item_t s1_item_reg;
    logic            s1_fwd_hit_reg;
    jste_pkg::time_t s1_fwd_data_reg;

    logic                          out_valid_reg;
    logic [jste_pkg::END_BITS-1:0] out_end_reg;
    jste_pkg::sum_t                out_sum_reg;
    logic                          out_done_reg;

    jste_pkg::sum_t                  sum_reg;
    logic [jste_pkg::JOB_DEPTH-1:0]  job_valid_reg;
    jste_pkg::time_t                 mach_ready_reg [jste_pkg::MACH_DEPTH];

    logic                          ram_wr_en;
    logic [jste_pkg::JOB_AW-1:0]   ram_wr_addr;
    jste_pkg::time_t               ram_wr_data;
    logic [jste_pkg::JOB_AW-1:0]   ram_rd_addr;
    jste_pkg::time_t               ram_rd_data;

    logic                          mach_ok;
    logic                          job_ok;
    logic [jste_pkg::MACH_AW-1:0]  mach_idx;
    logic [jste_pkg::JOB_AW-1:0]   job_idx;
    jste_pkg::time_t               mr;
    jste_pkg::time_t               jr;
    jste_pkg::time_t               start;
    logic [jste_pkg::EXT_BITS-1:0] end_ext;
    jste_pkg::time_t               end_sat;
    logic [jste_pkg::CMP_BITS-1:0] jr_c;
    logic [jste_pkg::CMP_BITS-1:0] due_c;
    logic [jste_pkg::CMP_BITS-1:0] late;
    logic [jste_pkg::ACC_BITS-1:0] acc;
    jste_pkg::sum_t                sum_sat;
    logic                          is_task;
    logic                          clear;

    // input packing and handshake
    assign in_item = '{
        func:         item.func,
        task_machine: item.task_machine,
        task_job:     item.task_job,
        duration:     item.duration,
        due_date:     item.due_date,
        last_due:     item.last_due
    };

    assign s1_fire    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_fire;
    assign in_fire    = item.valid && item.ready;

    // job ready table
    assign ram_rd_addr = in_item.task_job[jste_pkg::JOB_AW-1:0];

    jste_ram #(
        .WIDTH (jste_pkg::TIME_BITS),
        .DEPTH (jste_pkg::JOB_DEPTH)
    ) u_job_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_fire),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // evaluation
    always_comb
    begin
        is_task  = (s1_item_reg.func == jste_pkg::FUNC_TASK);
        mach_ok  = (32'(s1_item_reg.task_machine) < jste_pkg::MACHINES);
        job_ok   = (32'(s1_item_reg.task_job) < jste_pkg::JOBS);
        mach_idx = s1_item_reg.task_machine[jste_pkg::MACH_AW-1:0];
        job_idx  = s1_item_reg.task_job[jste_pkg::JOB_AW-1:0];

        mr = mach_ok ? mach_ready_reg[mach_idx] : '0;
        if (job_ok && job_valid_reg[job_idx])
        begin
            jr = s1_fwd_hit_reg ? s1_fwd_data_reg : ram_rd_data;
        end
        else
        begin
            jr = '0;
        end

        start   = (mr > jr) ? mr : jr;
        end_ext = jste_pkg::EXT_BITS'(start)
                + jste_pkg::EXT_BITS'(s1_item_reg.duration);
        end_sat = (end_ext > jste_pkg::EXT_BITS'(jste_pkg::TIME_MAX))
                ? jste_pkg::TIME_MAX : jste_pkg::TIME_BITS'(end_ext);

        jr_c  = jste_pkg::CMP_BITS'(jr);
        due_c = jste_pkg::CMP_BITS'(s1_item_reg.due_date);
        late  = (jr_c > due_c) ? (jr_c - due_c) : '0;
        acc   = jste_pkg::ACC_BITS'(sum_reg) + jste_pkg::ACC_BITS'(late);
        sum_sat = (|acc[jste_pkg::ACC_BITS-1:jste_pkg::SUM_BITS])
                ? jste_pkg::SUM_MAX : acc[jste_pkg::SUM_BITS-1:0];

        clear = s1_fire && !is_task && s1_item_reg.last_due;

        ram_wr_en   = s1_fire && is_task && job_ok;
        ram_wr_addr = job_idx;
        ram_wr_data = end_sat;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            job_valid_reg <= '0;
            for (int i = 0; i < jste_pkg::MACH_DEPTH; i++)
            begin
                mach_ready_reg[i] <= '0;
            end
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (clear)
            begin
                sum_reg       <= '0;
                job_valid_reg <= '0;
                for (int i = 0; i < jste_pkg::MACH_DEPTH; i++)
                begin
                    mach_ready_reg[i] <= '0;
                end
            end
            else if (s1_fire && is_task)
            begin
                if (mach_ok)
                begin
                    mach_ready_reg[mach_idx] <= end_sat;
                end
                if (job_ok)
                begin
                    job_valid_reg[job_idx] <= 1'b1;
                end
            end
            else if (s1_fire)
            begin
                sum_reg <= sum_sat;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg     <= in_item;
            s1_fwd_hit_reg  <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
            s1_fwd_data_reg <= ram_wr_data;
        end
        if (s1_fire)
        begin
            if (is_task)
            begin
                out_end_reg  <= jste_pkg::END_BITS'(end_sat);
                out_sum_reg  <= sum_reg;
                out_done_reg <= 1'b0;
            end
            else
            begin
                out_end_reg  <= jste_pkg::END_BITS'(jr);
                out_sum_reg  <= sum_sat;
                out_done_reg <= s1_item_reg.last_due;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.end_time        = out_end_reg;
    assign result.tardiness_total = out_sum_reg;
    assign result.total_done      = out_done_reg;

    // checks
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("input stalled without a pending transaction");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (sum_reg == '0 && job_valid_reg == '0))
        else $error("stores not cleared after last due transaction");

    a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !is_task && !clear) |=> (sum_reg >= $past(sum_reg)))
        else $error("tardiness sum decreased");

    a_task_sum_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && is_task) |=> (out_sum_reg == sum_reg && !out_done_reg))
        else $error("task transaction changed the tardiness sum");

endmodule

// File: sv/jste_ram.sv
// ----------------------------------------------------------------------------
// jste_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: bench/tb_job_shop_tardiness_evaluator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_job_shop_tardiness_evaluator_unit
// Drives schedules of task and due-date transactions into the evaluator and
// checks every result, in order, against a cycle-free model of the machine
// and job ready tables and the saturating tardiness sum. Covers field
// extremes, ignored fields, time and sum saturation, repeated due checks
// and the clear on the last due item, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_job_shop_tardiness_evaluator_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 950;
    localparam int CALM_AFTER  = 800;

    typedef struct {
        logic [jste_pkg::END_BITS-1:0] end_time;
        jste_pkg::sum_t                total;
        logic                          done;
    } tardiness_result_t;

    class tardiness_scoreboard;
        jste_pkg::time_t   machine_ready [jste_pkg::MACHINES];
        jste_pkg::time_t   job_ready [jste_pkg::JOBS];
        jste_pkg::sum_t    tardiness_sum;
        tardiness_result_t expected_q [$];
        int                errors;

        function new();
            errors = 0;
            clear_tables();
        endfunction

        function void clear_tables();
            foreach (machine_ready[i]) machine_ready[i] = '0;
            foreach (job_ready[i]) job_ready[i] = '0;
            tardiness_sum = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(jste_pkg::item_t it);
            tardiness_result_t                 r;
            jste_pkg::time_t                   jr;
            jste_pkg::time_t                   mr;
            jste_pkg::time_t                   start;
            jste_pkg::time_t                   done_at;
            logic [jste_pkg::TIME_BITS:0]      wide;
            logic [jste_pkg::CMP_BITS-1:0]     late;
            logic [jste_pkg::SUM_BITS:0]       acc;
            jr = job_ready[it.task_job];
            if (it.func == jste_pkg::FUNC_TASK) begin
                mr = machine_ready[it.task_machine];
                start = (mr > jr) ? mr : jr;
                wide = {1'b0, start}
                     + {{(jste_pkg::TIME_BITS + 1 - jste_pkg::DUR_BITS){1'b0}}, it.duration};
                done_at = wide[jste_pkg::TIME_BITS] ? jste_pkg::TIME_MAX
                                                    : wide[jste_pkg::TIME_BITS-1:0];
                machine_ready[it.task_machine] = done_at;
                job_ready[it.task_job] = done_at;
                r.end_time = done_at;
                r.total = tardiness_sum;
                r.done = 1'b0;
            end
            else begin
                late = (jr > it.due_date) ? jr - it.due_date : '0;
                acc = {1'b0, tardiness_sum} + (jste_pkg::SUM_BITS + 1)'(late);
                tardiness_sum = acc[jste_pkg::SUM_BITS] ? jste_pkg::SUM_MAX
                                                        : acc[jste_pkg::SUM_BITS-1:0];
                r.end_time = jr;
                r.total = tardiness_sum;
                r.done = it.last_due;
                if (it.last_due)
                    clear_tables();
            end
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 50)
                $display("ERROR at %0t ns: %s", $time, what);
        endtask

        task check_result(logic [jste_pkg::END_BITS-1:0] end_time, jste_pkg::sum_t total,
                          logic done);
            tardiness_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result 0x%0h/0x%0h/%0b with nothing pending",
                                          end_time, total, done));
            end
            else begin
                want = expected_q.pop_front();
                if (end_time !== want.end_time)
                    report_mismatch($sformatf("end_time got 0x%0h expected 0x%0h",
                                              end_time, want.end_time));
                if (total !== want.total)
                    report_mismatch($sformatf("tardiness_total got 0x%0h expected 0x%0h",
                                              total, want.total));
                if (done !== want.done)
                    report_mismatch($sformatf("total_done got %b expected %b",
                                              done, want.done));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   sent_count = 0;
    bit   idle_on = 1'b1;

    tardiness_scoreboard sb = new();

    jste_item_if   item_ch ();
    jste_result_if result_ch ();

    job_shop_tardiness_evaluator_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb_job_shop_tardiness_evaluator_unit: done, errors");
        $finish;
    end

    // result side: check each transaction, stall ready in random bursts
    initial
    begin
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.end_time, result_ch.tardiness_total,
                                result_ch.total_done);
            if (stall > 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 12) - 1;
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input jste_pkg::item_t it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.func         <= it.func;
        item_ch.task_machine <= it.task_machine;
        item_ch.task_job     <= it.task_job;
        item_ch.duration     <= it.duration;
        item_ch.due_date     <= it.due_date;
        item_ch.last_due     <= it.last_due;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(it);
        sent_count++;
    endtask

    // ignored fields carry random values
    task automatic put_task(input int m, input int j,
                            input logic [jste_pkg::DUR_BITS-1:0] dur);
        jste_pkg::item_t it;
        it.func         = jste_pkg::FUNC_TASK;
        it.task_machine = jste_pkg::MACH_BITS'(m);
        it.task_job     = jste_pkg::JOB_BITS'(j);
        it.duration     = dur;
        it.due_date     = jste_pkg::DUE_BITS'($urandom);
        it.last_due     = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic put_due(input int j, input logic [jste_pkg::DUE_BITS-1:0] due,
                           input logic last);
        jste_pkg::item_t it;
        it.func         = jste_pkg::FUNC_DUE;
        it.task_machine = jste_pkg::MACH_BITS'($urandom_range(0, 15));
        it.task_job     = jste_pkg::JOB_BITS'(j);
        it.duration     = jste_pkg::DUR_BITS'($urandom);
        it.due_date     = due;
        it.last_due     = last;
        send_item(it);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [jste_pkg::DUE_BITS-1:0] pick_due(input int j);
        jste_pkg::time_t jr;
        jr = sb.job_ready[j];
        case ($urandom_range(0, 3))
            0: return jste_pkg::DUE_BITS'($urandom);
            1: return jr;
            2: return jste_pkg::DUE_BITS'(jr + $urandom_range(0, 64));
            default: return jste_pkg::DUE_BITS'(jr - $urandom_range(0, 64));
        endcase
    endfunction

    task automatic run_schedule();
        int   n_tasks;
        int   n_dues;
        int   span;
        bit   wide_dur;
        n_tasks = $urandom_range(3, 40);
        n_dues = $urandom_range(1, 10);
        span = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(0, 15);
        wide_dur = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_tasks; i++) begin
            if ($urandom_range(0, 19) == 0)
                put_due($urandom_range(0, 63), jste_pkg::DUE_BITS'($urandom),
                        $urandom_range(0, 4) == 0);
            else
                put_task($urandom_range(0, 15), $urandom_range(0, span),
                         jste_pkg::DUR_BITS'(wide_dur ? $urandom : $urandom_range(0, 400)));
        end
        for (int i = 0; i < n_dues; i++) begin
            int j;
            j = $urandom_range(0, span);
            put_due(j, pick_due(j), (i == n_dues - 1) && ($urandom_range(0, 9) != 0));
        end
    endtask

    // one machine chained until times and then the sum saturate
    task automatic run_saturation();
        int m;
        int j;
        m = $urandom_range(0, 15);
        j = 0;
        for (int i = 0; i < 260; i++) begin
            j = $urandom_range(0, 63);
            put_task(m, j, '1);
        end
        for (int i = 0; i < 259; i++)
            put_due(j, jste_pkg::DUE_BITS'($urandom_range(0, 1000)), 1'b0);
        put_due($urandom_range(0, 63), '0, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.func = jste_pkg::FUNC_TASK;
        item_ch.task_machine = '0;
        item_ch.task_job = '0;
        item_ch.duration = '0;
        item_ch.due_date = '0;
        item_ch.last_due = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_task(0, 0, 16'd0);
        put_task(15, 63, 16'hFFFF);
        put_task(15, 0, 16'd1);
        put_task(3, 63, 16'd5);
        put_task(3, 1, 16'd0);
        put_due(63, 24'd0, 1'b0);
        put_due(63, 24'hFFFFFF, 1'b0);
        put_due(0, 24'd65536, 1'b0);
        put_due(63, 24'd65539, 1'b0);
        put_due(10, 24'd0, 1'b0);
        put_task(7, 2, 16'hAAAA);
        put_task(7, 2, 16'h5555);
        put_due(2, 24'd0, 1'b1);
        drain();
        put_task(15, 63, 16'd7);
        put_due(63, 24'd0, 1'b1);
        put_due(63, 24'd0, 1'b1);
        put_due(0, 24'hFFFFFF, 1'b0);
        put_due(0, 24'd0, 1'b1);

        while (sent_count < 150) begin
            idle_on = ($urandom_range(0, 3) != 0);
            run_schedule();
        end
        idle_on = 1'b1;
        run_saturation();
        drain();
        while (sent_count < ITEM_TARGET) begin
            idle_on = (sent_count < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            run_schedule();
        end
        item_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_job_shop_tardiness_evaluator_unit: done, clean");
        else
            $display("tb_job_shop_tardiness_evaluator_unit: done, errors");
        $finish;
    end

endmodule

// File: job_shop_tardiness_evaluator_unit.f
sv/jste_pkg.sv
sv/jste_item_if.sv
sv/jste_result_if.sv
sv/jste_ram.sv
sv/job_shop_tardiness_evaluator_unit.sv
bench/tb_job_shop_tardiness_evaluator_unit.sv
